### src/aapr_pkg.sv
// ----------------------------------------------------------------------------
// aapr_pkg: shared types and constants
// Widths, CORDIC arctangent table and fixed-point constants for the rotation
// block.
// ----------------------------------------------------------------------------
package aapr_pkg;

    localparam int DefCordicSteps = 24;
    localparam int DefCoordWidth  = 32;
    localparam int FieldWidth     = 32;
    localparam int CordicWidth    = 36;

    localparam logic signed [CordicWidth-1:0] Q30Pi     = 36'sd3373259426;
    localparam logic signed [CordicWidth-1:0] Q30HalfPi = 36'sd1686629713;
    localparam logic signed [CordicWidth-1:0] CordicK   = 36'sd652032874;

    typedef logic signed [FieldWidth-1:0]  field_t;
    typedef logic signed [CordicWidth-1:0] cword_t;

    // one beat travelling down the cordic chain
    typedef struct packed {
        logic   vld;
        logic   flip;
        cword_t x;
        cword_t y;
        cword_t z;
        field_t px;
        field_t py;
        field_t pz;
        field_t ox;
        field_t oy;
        field_t oz;
        field_t ax;
        field_t ay;
        field_t az;
    } cbeat_t;

    function automatic cword_t atan_q30(input logic [4:0] i);
        case (i)
            5'd0:  atan_q30 = 36'sh03243F6A8;
            5'd1:  atan_q30 = 36'sh01DAC6705;
            5'd2:  atan_q30 = 36'sh00FADBAFC;
            5'd3:  atan_q30 = 36'sh007F56EA6;
            5'd4:  atan_q30 = 36'sh003FEAB76;
            5'd5:  atan_q30 = 36'sh001FFD55B;
            5'd6:  atan_q30 = 36'sh000FFFAAA;
            5'd7:  atan_q30 = 36'sh0007FFF55;
            5'd8:  atan_q30 = 36'sh0003FFFEA;
            5'd9:  atan_q30 = 36'sh0001FFFFD;
            5'd10: atan_q30 = 36'sh0000FFFFF;
            5'd11: atan_q30 = 36'sh00007FFFF;
            5'd12: atan_q30 = 36'sh00003FFFF;
            5'd13: atan_q30 = 36'sh00001FFFF;
            5'd14: atan_q30 = 36'sh00000FFFF;
            5'd15: atan_q30 = 36'sh000007FFF;
            5'd16: atan_q30 = 36'sh000003FFF;
            5'd17: atan_q30 = 36'sh000001FFF;
            5'd18: atan_q30 = 36'sh000000FFF;
            5'd19: atan_q30 = 36'sh0000007FF;
            5'd20: atan_q30 = 36'sh0000003FF;
            5'd21: atan_q30 = 36'sh0000001FF;
            5'd22: atan_q30 = 36'sh0000000FF;
            5'd23: atan_q30 = 36'sh00000007F;
            5'd24: atan_q30 = 36'sh00000003F;
            5'd25: atan_q30 = 36'sh00000001F;
            5'd26: atan_q30 = 36'sh00000000F;
            5'd27: atan_q30 = 36'sh000000008;
            5'd28: atan_q30 = 36'sh000000004;
            5'd29: atan_q30 = 36'sh000000002;
            5'd30: atan_q30 = 36'sh000000001;
            default: atan_q30 = '0;
        endcase
    endfunction

endpackage

### src/axis_angle_point_rotation.sv
// ----------------------------------------------------------------------------
// axis_angle_point_rotation: rotate a point about an axis through an origin
// Angle folded to +/- pi/2, a chain of cordic cells gives cos and sin, then
// a pipelined Rodrigues matrix transform adds the origin back and saturates.
//
//   channel | direction | handshake      | payload
//   input   | in        | in_valid/stall | point, origin, axis, angle
//   output  | out       | out_valid/stall| rotated_x/y/z
//
// one beat per cycle while the skid is empty; the path runs through a fold
// register, one cell per cordic step, six transform stages, output register
// reset clears only the valid flags of the chain, the output register and the skid
// a stall on the output freezes the whole chain once the skid is full; a free
// skid keeps input accepted while a finished beat waits
// ----------------------------------------------------------------------------
module axis_angle_point_rotation #(
    parameter int CORDIC_STEPS = aapr_pkg::DefCordicSteps,
    parameter int COORD_WIDTH  = aapr_pkg::DefCoordWidth
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  aapr_pkg::field_t point_x,
    input  aapr_pkg::field_t point_y,
    input  aapr_pkg::field_t point_z,
    input  aapr_pkg::field_t origin_x,
    input  aapr_pkg::field_t origin_y,
    input  aapr_pkg::field_t origin_z,
    input  aapr_pkg::field_t axis_x,
    input  aapr_pkg::field_t axis_y,
    input  aapr_pkg::field_t axis_z,
    input  aapr_pkg::field_t angle,
    output logic             out_valid,
    input  logic             out_stall,
    output aapr_pkg::field_t rotated_x,
    output aapr_pkg::field_t rotated_y,
    output aapr_pkg::field_t rotated_z
);
    import aapr_pkg::*;

    cbeat_t chain [CORDIC_STEPS+1];
    cbeat_t fold_next;
    cbeat_t fold_reg;
    cbeat_t fold_out;
    logic   fold_vld_reg;
    cword_t z0;

    logic   adv;
    logic   mvld;
    field_t mx, my, mz;

    // output register plus one skid entry
    logic   ov_reg, sv_reg;
    field_t ox_reg, oy_reg, oz_reg;
    field_t sx_reg, sy_reg, sz_reg;

    // the pipe moves when the skid is empty
    assign adv      = !sv_reg;
    assign in_stall = sv_reg;

    // fold the angle into +/- pi/2
    always_comb
    begin
        z0 = cword_t'(angle) <<< 1;
        fold_next.vld  = in_valid;
        fold_next.flip = 1'b0;
        fold_next.z    = z0;
        if (z0 > Q30HalfPi)
        begin
            fold_next.z    = z0 - Q30Pi;
            fold_next.flip = 1'b1;
        end
        else if (z0 < -Q30HalfPi)
        begin
            fold_next.z    = z0 + Q30Pi;
            fold_next.flip = 1'b1;
        end
        fold_next.x  = CordicK;
        fold_next.y  = '0;
        fold_next.px = point_x;
        fold_next.py = point_y;
        fold_next.pz = point_z;
        fold_next.ox = origin_x;
        fold_next.oy = origin_y;
        fold_next.oz = origin_z;
        fold_next.ax = axis_x;
        fold_next.ay = axis_y;
        fold_next.az = axis_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            fold_vld_reg <= fold_next.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fold_reg <= fold_next;
        end
    end

    // valid flag comes from the reset register
    always_comb
    begin
        fold_out     = fold_reg;
        fold_out.vld = fold_vld_reg;
    end

    assign chain[0] = fold_out;

    // row of cordic cells, one micro-rotation each
    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_cell
        aapr_cordic_cell #(
            .STEP (g)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .din   (chain[g]),
            .dout  (chain[g+1])
        );
    end

    aapr_matrix #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_matrix (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .din   (chain[CORDIC_STEPS]),
        .vld   (mvld),
        .rx    (mx),
        .ry    (my),
        .rz    (mz)
    );

    // output register with skid: the pipe pushes while adv, the skid
    // catches a beat that arrives while the output is held
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            sv_reg <= 1'b0;
        end
        else
        begin
            if (!ov_reg || !out_stall)
            begin
                if (sv_reg)
                begin
                    ov_reg <= 1'b1;
                    sv_reg <= 1'b0;
                end
                else
                begin
                    ov_reg <= mvld;
                end
            end
            else if (adv && mvld)
            begin
                sv_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ov_reg || !out_stall)
        begin
            if (sv_reg)
            begin
                ox_reg <= sx_reg;
                oy_reg <= sy_reg;
                oz_reg <= sz_reg;
            end
            else
            begin
                ox_reg <= mx;
                oy_reg <= my;
                oz_reg <= mz;
            end
        end
        else if (adv)
        begin
            sx_reg <= mx;
            sy_reg <= my;
            sz_reg <= mz;
        end
    end

    assign out_valid = ov_reg;
    assign rotated_x = ox_reg;
    assign rotated_y = oy_reg;
    assign rotated_z = oz_reg;

    // skid only fills while output is held
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sv_reg) |-> $past(ov_reg) && $past(out_stall))
        else $error("skid filled without a held output");

    // a full skid always has a full output register in front of it
    a_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        sv_reg |-> ov_reg)
        else $error("skid full with empty output");

    // held output keeps its beat
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && out_stall |=> ov_reg && $stable(rotated_x))
        else $error("held output changed");
endmodule

### src/aapr_cordic_cell.sv
// ----------------------------------------------------------------------------
// aapr_cordic_cell: one cordic micro-rotation
// Rotates by +/- atan(2^-STEP) and hands the beat to the next cell.
// ----------------------------------------------------------------------------
module aapr_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  aapr_pkg::cbeat_t din,
    output aapr_pkg::cbeat_t dout
);
    import aapr_pkg::*;

    cbeat_t beat_reg;
    cbeat_t beat_next;
    logic   vld_reg;
    cword_t dx;
    cword_t dy;

    always_comb
    begin
        dx = din.y >>> STEP;
        dy = din.x >>> STEP;
        beat_next = din;
        if (!din.z[CordicWidth-1])
        begin
            beat_next.x = din.x - dx;
            beat_next.y = din.y + dy;
            beat_next.z = din.z - atan_q30(5'(STEP));
        end
        else
        begin
            beat_next.x = din.x + dx;
            beat_next.y = din.y - dy;
            beat_next.z = din.z + atan_q30(5'(STEP));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= beat_next.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            beat_reg <= beat_next;
        end
    end

    // valid flag comes from the reset register
    always_comb
    begin
        dout     = beat_reg;
        dout.vld = vld_reg;
    end
endmodule

### src/aapr_matrix.sv
// ----------------------------------------------------------------------------
// aapr_matrix: rotation matrix and transform pipeline
// Builds the Rodrigues matrix from cos/sin and the axis, applies it to the
// origin-relative point, adds the origin back and saturates.
// ----------------------------------------------------------------------------
module aapr_matrix #(
    parameter int COORD_WIDTH = aapr_pkg::DefCoordWidth
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  aapr_pkg::cbeat_t din,
    output logic             vld,
    output aapr_pkg::field_t rx,
    output aapr_pkg::field_t ry,
    output aapr_pkg::field_t rz
);
    import aapr_pkg::*;

    localparam int SatW = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
    localparam logic signed [47:0] SatHi = 48'sd1 <<< (SatW - 1);

    // floor(a*b/2^30), operands fit in 34 bits
    function automatic logic signed [47:0] mq30(input logic signed [33:0] a,
                                               input logic signed [33:0] b);
        logic signed [67:0] p;
        p = a * b;
        mq30 = 48'($signed(p[67:30]));
    endfunction

    logic [5:0] v_reg;

    // stage 1: c, s, t, differences
    logic signed [47:0] c1_reg, s1_reg, t1_reg;
    logic signed [47:0] d1_reg [3];
    logic signed [47:0] a1_reg [3];
    logic signed [47:0] o1_reg [3];
    // stage 2: axis products and a*s
    logic signed [47:0] aa2_reg [3][3];
    logic signed [47:0] as2_reg [3];
    logic signed [47:0] c2_reg, t2_reg;
    logic signed [47:0] d2_reg [3];
    logic signed [47:0] o2_reg [3];
    // stage 3: t * aa
    logic signed [47:0] ta3_reg [3][3];
    logic signed [47:0] as3_reg [3];
    logic signed [47:0] c3_reg;
    logic signed [47:0] d3_reg [3];
    logic signed [47:0] o3_reg [3];
    // stage 4: matrix entries
    logic signed [47:0] m4_reg [3][3];
    logic signed [47:0] d4_reg [3];
    logic signed [47:0] o4_reg [3];
    // stage 5: products
    logic signed [47:0] pr5_reg [3][3];
    logic signed [47:0] o5_reg [3];
    // stage 6: sum and saturate
    field_t r6_reg [3];

    logic signed [CordicWidth-1:0] cx, sy;
    logic signed [47:0] acc [3];

    always_comb
    begin
        cx = din.flip ? -din.x : din.x;
        sy = din.flip ? -din.y : din.y;
        for (int r = 0; r < 3; r++)
        begin
            acc[r] = o5_reg[r] + pr5_reg[r][0] + pr5_reg[r][1] + pr5_reg[r][2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[4:0], din.vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_reg <= 48'(cx);
            s1_reg <= 48'(sy);
            t1_reg <= (48'sd1 <<< 30) - 48'(cx);
            d1_reg[0] <= 48'(din.px) - 48'(din.ox);
            d1_reg[1] <= 48'(din.py) - 48'(din.oy);
            d1_reg[2] <= 48'(din.pz) - 48'(din.oz);
            a1_reg[0] <= 48'(din.ax);
            a1_reg[1] <= 48'(din.ay);
            a1_reg[2] <= 48'(din.az);
            o1_reg[0] <= 48'(din.ox);
            o1_reg[1] <= 48'(din.oy);
            o1_reg[2] <= 48'(din.oz);

            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    aa2_reg[r][k] <= mq30(34'(a1_reg[r]), 34'(a1_reg[k]));
                    ta3_reg[r][k] <= mq30(34'(t2_reg), 34'(aa2_reg[r][k]));
                    pr5_reg[r][k] <= mq30(34'(m4_reg[r][k]), 34'(d4_reg[k]));
                end
                as2_reg[r] <= mq30(34'(a1_reg[r]), 34'(s1_reg));
                as3_reg[r] <= as2_reg[r];
                d2_reg[r] <= d1_reg[r];
                d3_reg[r] <= d2_reg[r];
                d4_reg[r] <= d3_reg[r];
                o2_reg[r] <= o1_reg[r];
                o3_reg[r] <= o2_reg[r];
                o4_reg[r] <= o3_reg[r];
                o5_reg[r] <= o4_reg[r];
                if (acc[r] >= SatHi)
                    r6_reg[r] <= field_t'(SatHi - 48'sd1);
                else if (acc[r] < -SatHi)
                    r6_reg[r] <= field_t'(-SatHi);
                else
                    r6_reg[r] <= field_t'(acc[r]);
            end
            c2_reg <= c1_reg;
            t2_reg <= t1_reg;
            c3_reg <= c2_reg;

            m4_reg[0][0] <= ta3_reg[0][0] + c3_reg;
            m4_reg[1][1] <= ta3_reg[1][1] + c3_reg;
            m4_reg[2][2] <= ta3_reg[2][2] + c3_reg;
            m4_reg[0][1] <= ta3_reg[0][1] - as3_reg[2];
            m4_reg[1][0] <= ta3_reg[1][0] + as3_reg[2];
            m4_reg[0][2] <= ta3_reg[0][2] + as3_reg[1];
            m4_reg[2][0] <= ta3_reg[2][0] - as3_reg[1];
            m4_reg[1][2] <= ta3_reg[1][2] - as3_reg[0];
            m4_reg[2][1] <= ta3_reg[2][1] + as3_reg[0];
        end
    end

    assign vld = v_reg[5];
    assign rx  = r6_reg[0];
    assign ry  = r6_reg[1];
    assign rz  = r6_reg[2];
endmodule

### test/axis_angle_point_rotation_tb.sv
// ----------------------------------------------------------------------------
// axis_angle_point_rotation_tb: self-checking bench for the rotation block
// Drives points, origins, axes and angles through the valid/stall input,
// predicts every rotated point in fixed point and compares each output beat
// in order. Sender bursts and receiver stalls vary throughout the run.
// ----------------------------------------------------------------------------
module axis_angle_point_rotation_tb;

    import aapr_pkg::*;

    localparam int      Steps     = 24;
    localparam int      Latency   = Steps + 8;
    localparam longint  HalfPiQ30 = 64'sd1686629713;
    localparam longint  PiQ30     = 64'sd3373259426;
    localparam longint  GainQ30   = 64'sd652032874;
    localparam longint  OneQ30    = 64'sd1073741824;
    localparam int      RandItems = 1030;

    typedef struct {
        field_t px, py, pz;
        field_t ox, oy, oz;
        field_t ax, ay, az;
        field_t ang;
    } rot_req_t;

    typedef struct {
        field_t x, y, z;
    } point_t;

    // atan(2^-i) in Q30, truncated
    localparam longint AtanTab [0:23] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_stall;
    field_t point_x, point_y, point_z;
    field_t origin_x, origin_y, origin_z;
    field_t axis_x, axis_y, axis_z;
    field_t angle;
    logic   out_valid;
    logic   out_stall;
    field_t rotated_x, rotated_y, rotated_z;

    point_t rotated_q[$];
    int     errors;
    int     burst_left;

    axis_angle_point_rotation dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .point_x  (point_x),
        .point_y  (point_y),
        .point_z  (point_z),
        .origin_x (origin_x),
        .origin_y (origin_y),
        .origin_z (origin_z),
        .axis_x   (axis_x),
        .axis_y   (axis_y),
        .axis_z   (axis_z),
        .angle    (angle),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .rotated_x(rotated_x),
        .rotated_y(rotated_y),
        .rotated_z(rotated_z)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // floor(a*b / 2^sh), exact, clamped to the 64-bit signed range
    function automatic longint mul_floor(longint a, longint b, int sh);
        logic signed [127:0] prod;
        logic signed [127:0] hi_lim;
        hi_lim = 128'sh7FFFFFFFFFFFFFFF;
        prod   = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
        prod   = prod >>> sh;
        if (prod > hi_lim)
            return 64'sh7FFFFFFFFFFFFFFF;
        if (prod < -hi_lim - 1)
            return 64'sh8000000000000000;
        return longint'(prod[63:0]);
    endfunction

    // fold into +/- pi/2, then rotation-mode cordic
    task automatic cordic_cos_sin(input field_t ang, output longint c, output longint s);
        longint x, y, z, dx, dy;
        logic   flip;
        z    = longint'(ang) * 2;
        x    = GainQ30;
        y    = 0;
        flip = 1'b0;
        if (z > HalfPiQ30)
        begin
            z    = z - PiQ30;
            flip = 1'b1;
        end
        else if (z < -HalfPiQ30)
        begin
            z    = z + PiQ30;
            flip = 1'b1;
        end
        for (int i = 0; i < Steps; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - AtanTab[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + AtanTab[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic field_t clamp_coord(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return field_t'(v);
    endfunction

    // rodrigues matrix applied to point minus origin, origin added back
    task automatic rotate_point(input rot_req_t r, output point_t res);
        longint c, s, t, acc, as;
        longint a[3], d[3], o[3];
        longint m[3][3];
        field_t out3[3];
        a[0] = r.ax;  a[1] = r.ay;  a[2] = r.az;
        o[0] = r.ox;  o[1] = r.oy;  o[2] = r.oz;
        d[0] = longint'(r.px) - o[0];
        d[1] = longint'(r.py) - o[1];
        d[2] = longint'(r.pz) - o[2];
        cordic_cos_sin(r.ang, c, s);
        t = OneQ30 - c;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = mul_floor(t, mul_floor(a[i], a[j], 30), 30);
        m[0][0] += c;
        m[1][1] += c;
        m[2][2] += c;
        as = mul_floor(a[2], s, 30);
        m[0][1] -= as;
        m[1][0] += as;
        as = mul_floor(a[1], s, 30);
        m[0][2] += as;
        m[2][0] -= as;
        as = mul_floor(a[0], s, 30);
        m[1][2] -= as;
        m[2][1] += as;
        for (int i = 0; i < 3; i++)
        begin
            acc = o[i];
            for (int j = 0; j < 3; j++)
                acc += mul_floor(m[i][j], d[j], 30);
            out3[i] = clamp_coord(acc);
        end
        res.x = out3[0];
        res.y = out3[1];
        res.z = out3[2];
    endtask

    // one input beat; sender bursts are counted here
    task automatic send_rotation(input rot_req_t r);
        point_t exp_pt;
        if (burst_left == 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 40);
        end
        else
            @(negedge clk);
        burst_left--;
        in_valid = 1'b1;
        point_x  = r.px;  point_y  = r.py;  point_z  = r.pz;
        origin_x = r.ox;  origin_y = r.oy;  origin_z = r.oz;
        axis_x   = r.ax;  axis_y   = r.ay;  axis_z   = r.az;
        angle    = r.ang;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        rotate_point(r, exp_pt);
        rotated_q.push_back(exp_pt);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (rotated_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic rot_req_t make_req(field_t px, field_t py, field_t pz,
                                          field_t ox, field_t oy, field_t oz,
                                          field_t ax, field_t ay, field_t az,
                                          field_t ang);
        rot_req_t r;
        r.px = px;  r.py = py;  r.pz = pz;
        r.ox = ox;  r.oy = oy;  r.oz = oz;
        r.ax = ax;  r.ay = ay;  r.az = az;
        r.ang = ang;
        return r;
    endfunction

    function automatic field_t rand_angle();
        return field_t'(longint'($urandom_range(32'd3373259426)) - HalfPiQ30);
    endfunction

    function automatic field_t rand_axis_comp();
        return field_t'(longint'($urandom_range(32'h80000000)) - OneQ30);
    endfunction

    // small coordinate, within +/- 2^(bits-1) in Q16.16 lsbs
    function automatic field_t rand_coord(int bits);
        return field_t'($urandom) >>> (32 - bits);
    endfunction

    task automatic test_directed();
        localparam field_t One = 32'sh00010000;
        localparam field_t Max = 32'sh7FFFFFFF;
        localparam field_t Min = 32'sh80000000;
        localparam field_t Ax1 = 32'sh40000000;
        localparam field_t AxN = -32'sh40000000;
        localparam field_t Pi2 = 32'sh3243F6A8;
        localparam field_t PiA = 32'sh6487ED51;
        // zero angle, eighth turns about each principal axis
        send_rotation(make_req(One, 0, 0, 0, 0, 0, 0, 0, Ax1, 0));
        send_rotation(make_req(One, 0, 0, 0, 0, 0, 0, 0, Ax1, Pi2 >>> 1));
        send_rotation(make_req(0, One, 0, 0, 0, 0, Ax1, 0, 0, Pi2 >>> 1));
        send_rotation(make_req(0, 0, One, 0, 0, 0, 0, Ax1, 0, -(Pi2 >>> 1)));
        // plus and minus pi, then plus and minus pi/2 at the fold edge
        send_rotation(make_req(One, One, One, 0, 0, 0, 0, AxN, 0, PiA));
        send_rotation(make_req(One, -One, One, 0, 0, 0, Ax1, 0, 0, -PiA));
        send_rotation(make_req(One, 0, 0, 0, 0, 0, 0, 0, Ax1, Pi2));
        send_rotation(make_req(One, 0, 0, 0, 0, 0, 0, 0, Ax1, -Pi2));
        send_rotation(make_req(One, 0, 0, 0, 0, 0, 0, 0, Ax1, Pi2 + 1));
        // angle beyond pi, field extremes
        send_rotation(make_req(One, 2 * One, 3 * One, One, 0, 0, Ax1, 0, 0, Max));
        send_rotation(make_req(One, 2 * One, 3 * One, 0, One, 0, 0, Ax1, 0, Min));
        // non-unit axis: zero, all components at one, all negative
        send_rotation(make_req(One, One, One, 0, 0, 0, 0, 0, 0, Pi2));
        send_rotation(make_req(One, One, One, 0, 0, 0, Ax1, Ax1, Ax1, Pi2 >>> 2));
        send_rotation(make_req(One, One, One, 0, 0, 0, AxN, AxN, AxN, -Pi2));
        // coordinate overflow and saturation
        send_rotation(make_req(Max, Max, Max, Min, Min, Min, 0, 0, Ax1, Pi2 >>> 1));
        send_rotation(make_req(Min, Min, Min, Max, Max, Max, Ax1, 0, 0, PiA));
        send_rotation(make_req(Max, Min, Max, Min, Max, Min, AxN, AxN, Ax1, Max));
        send_rotation(make_req(Max, Max, Max, 0, 0, 0, 0, 0, 0, 0));
        send_rotation(make_req(Min, Min, Min, Min, Min, Min, Ax1, Ax1, Ax1, Min));
        send_rotation(make_req(Max, Max, Max, Max, Max, Max, AxN, AxN, AxN, Max));
        wait_drained();
    endtask

    task automatic test_random();
        rot_req_t r;
        real      vx, vy, vz, nrm;
        for (int n = 0; n < RandItems; n++)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    // raw noise over every bit of points, origins and angle
                    r = make_req($urandom, $urandom, $urandom, $urandom, $urandom,
                                 $urandom, rand_axis_comp(), rand_axis_comp(),
                                 rand_axis_comp(), $urandom);
                end
                2:
                begin
                    // large coordinates near saturation, principal-ish axes
                    r = make_req($urandom, $urandom, $urandom, rand_coord(32),
                                 rand_coord(32), rand_coord(32), rand_axis_comp(),
                                 0, 0, rand_angle());
                end
                default:
                begin
                    // unit axis, moderate coordinates
                    vx  = real'($urandom_range(0, 2000)) - 1000.0;
                    vy  = real'($urandom_range(0, 2000)) - 1000.0;
                    vz  = real'($urandom_range(0, 2000)) - 1000.0;
                    nrm = $sqrt(vx * vx + vy * vy + vz * vz);
                    if (nrm < 1.0)
                    begin
                        vz  = 1.0;
                        nrm = 1.0;
                    end
                    r = make_req(rand_coord(26), rand_coord(26), rand_coord(26),
                                 rand_coord(24), rand_coord(24), rand_coord(24),
                                 field_t'($rtoi(vx / nrm * 1073741824.0)),
                                 field_t'($rtoi(vy / nrm * 1073741824.0)),
                                 field_t'($rtoi(vz / nrm * 1073741824.0)),
                                 rand_angle());
                end
            endcase
            send_rotation(r);
            // hold off once mid run until the pipe is empty
            if (n == RandItems / 2)
                wait_drained();
        end
    endtask

    // receiver stall pattern: mode is drawn anew whenever stall_cnt wraps to zero
    int stall_mode;
    int stall_cnt;
    always @(negedge clk)
    begin
        if (stall_cnt == 0)
            stall_mode <= $urandom_range(0, 3);
        stall_cnt <= (stall_cnt + 1) % 64;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 9) < 3);
            2:       out_stall <= (stall_cnt % 8) >= 5;
            default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    // output checker: each beat against the oldest prediction
    always @(posedge clk)
    begin
        point_t exp_pt;
        if (rst_n && out_valid && !out_stall)
        begin
            if (rotated_q.size() == 0)
            begin
                $display("%0t: unexpected beat, got x=%0d y=%0d z=%0d", $time,
                         rotated_x, rotated_y, rotated_z);
                errors++;
            end
            else
            begin
                exp_pt = rotated_q.pop_front();
                if (rotated_x !== exp_pt.x)
                begin
                    $display("%0t: rotated_x expected %0d got %0d", $time, exp_pt.x, rotated_x);
                    errors++;
                end
                if (rotated_y !== exp_pt.y)
                begin
                    $display("%0t: rotated_y expected %0d got %0d", $time, exp_pt.y, rotated_y);
                    errors++;
                end
                if (rotated_z !== exp_pt.z)
                begin
                    $display("%0t: rotated_z expected %0d got %0d", $time, exp_pt.z, rotated_z);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("axis_angle_point_rotation_tb: errors");
        $finish;
    end

    initial
    begin
        errors     = 0;
        burst_left = 0;
        stall_mode = 0;
        stall_cnt  = 0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        out_stall  = 1'b0;
        point_x    = '0;  point_y  = '0;  point_z  = '0;
        origin_x   = '0;  origin_y = '0;  origin_z = '0;
        axis_x     = '0;  axis_y   = '0;  axis_z   = '0;
        angle      = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random();
        wait_drained();
        // tail: make sure no stray beat follows
        repeat (Latency * 4) @(posedge clk);

        if (errors == 0)
            $display("axis_angle_point_rotation_tb: clean");
        else
            $display("axis_angle_point_rotation_tb: errors");
        $finish;
    end

endmodule

### files.f
src/aapr_pkg.sv
src/aapr_cordic_cell.sv
src/aapr_matrix.sv
src/axis_angle_point_rotation.sv
test/axis_angle_point_rotation_tb.sv
